// File: sv/dtlq_pkg.sv
// Shared constants and control types for the tail-drop link queue.
package dtlq_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int HELD_W       = $clog2(BUFFER_DEPTH + 1);

    localparam int TIME_W  = 48;
    localparam int SIZE_W  = 16;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 48;
    localparam int LIMIT_W = 7;
    localparam int RATE_W  = 17;

    // one queue entry: arrival time above packet size
    localparam int ENTRY_W = TIME_W + SIZE_W;

    // service time numerator: bytes * 8000
    localparam int BITS_PER_KBYTE = 8000;
    localparam int NUM_W          = 29;
    localparam int DIV_CNT_W      = $clog2(NUM_W + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(100);

    // configuration register indexes
    localparam logic REG_BUFFER_LIMIT = 1'b0;
    localparam logic REG_LINK_RATE    = 1'b1;

    typedef struct packed {
        logic latch;      // capture the incoming item
        logic retire;     // retire the head packet
        logic next_start; // charge the new head's wait and start its service divide
        logic admit;      // count the arrival and queue or drop it
        logic load_dep;   // take the divide result as the head departure time
        logic done;       // present the result beat
    } dtlq_cmd_t;

    typedef struct packed {
        logic retire_ok;  // head departs at or before the item time (or drain)
        logic more_held;  // more than one packet held
        logic div_needed; // an admit now would start service at once
        logic div_done;   // divide result ready
    } dtlq_status_t;

endpackage

// File: sv/drop_tail_link_queue.sv
// Top level of the tail-drop link queue: sequencer plus datapath.
// An item (arrival or drain) is taken while busy is low and start is high. Each
// retired packet with a successor, and each arrival queued into an empty buffer,
// waits for the one-bit-per-cycle service-time divider (29 quotient bits); a
// retired packet that empties the buffer starts no divide. The result beat
// appears on done for exactly one cycle as busy falls, and must be taken then:
// the receiver cannot stall. Configuration writes are always ready and should
// be issued only while busy is low.
module drop_tail_link_queue
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [dtlq_pkg::TIME_W-1:0]       arrival_time_ns,
    input  logic [dtlq_pkg::SIZE_W-1:0]       packet_bytes,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [dtlq_pkg::RATE_W-1:0]       cfg_data,
    output logic                              done,
    output logic                              admitted,
    output logic [dtlq_pkg::LIMIT_W-1:0]      occupancy,
    output logic [dtlq_pkg::CNT_W-1:0]        packets_in,
    output logic [dtlq_pkg::SUM_W-1:0]        bytes_in,
    output logic [dtlq_pkg::CNT_W-1:0]        packets_out,
    output logic [dtlq_pkg::SUM_W-1:0]        bytes_out,
    output logic [dtlq_pkg::CNT_W-1:0]        packets_lost,
    output logic [dtlq_pkg::SUM_W-1:0]        bytes_lost,
    output logic [dtlq_pkg::SUM_W-1:0]        delay_total_ns
);

    dtlq_pkg::dtlq_cmd_t    cmd;
    dtlq_pkg::dtlq_status_t status;

    assign cfg_ready = 1'b1;
    assign done      = cmd.done;

    // sequencer
    dtlq_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // datapath
    dtlq_dpath u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .arrival_time_ns (arrival_time_ns),
        .packet_bytes    (packet_bytes),
        .cmd             (cmd),
        .status          (status),
        .admitted        (admitted),
        .occupancy       (occupancy),
        .packets_in      (packets_in),
        .bytes_in        (bytes_in),
        .packets_out     (packets_out),
        .bytes_out       (bytes_out),
        .packets_lost    (packets_lost),
        .bytes_lost      (bytes_lost),
        .delay_total_ns  (delay_total_ns)
    );

endmodule

// File: sv/dtlq_ctrl.sv
// Sequencer for retire, admit and service-time divide steps.
module dtlq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  dtlq_pkg::dtlq_status_t status,
    output dtlq_pkg::dtlq_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CHECK,
        ST_RET_RD,
        ST_RET_NEXT,
        ST_DIV_RET,
        ST_DIV_ADM
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        cmd            = '0;
        cmd.done       = done_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.retire_ok)
                begin
                    state_next = ST_RET_RD;
                end
                else
                begin
                    cmd.admit = 1'b1;
                    if (status.div_needed)
                    begin
                        state_next = ST_DIV_ADM;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RET_RD:
            begin
                cmd.retire = 1'b1;
                state_next = status.more_held ? ST_RET_NEXT : ST_CHECK;
            end
            ST_RET_NEXT:
            begin
                cmd.next_start = 1'b1;
                state_next     = ST_DIV_RET;
            end
            ST_DIV_RET:
            begin
                if (status.div_done)
                begin
                    cmd.load_dep = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_DIV_ADM:
            begin
                if (status.div_done)
                begin
                    cmd.load_dep = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: sv/dtlq_dpath.sv
// Queue storage, counters, configuration and the service-time divider.
module dtlq_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_index,
    input  logic [dtlq_pkg::RATE_W-1:0]         cfg_data,
    input  logic                                mode,
    input  logic [dtlq_pkg::TIME_W-1:0]         arrival_time_ns,
    input  logic [dtlq_pkg::SIZE_W-1:0]         packet_bytes,
    input  dtlq_pkg::dtlq_cmd_t                 cmd,
    output dtlq_pkg::dtlq_status_t              status,
    output logic                                admitted,
    output logic [dtlq_pkg::LIMIT_W-1:0]        occupancy,
    output logic [dtlq_pkg::CNT_W-1:0]          packets_in,
    output logic [dtlq_pkg::SUM_W-1:0]          bytes_in,
    output logic [dtlq_pkg::CNT_W-1:0]          packets_out,
    output logic [dtlq_pkg::SUM_W-1:0]          bytes_out,
    output logic [dtlq_pkg::CNT_W-1:0]          packets_lost,
    output logic [dtlq_pkg::SUM_W-1:0]          bytes_lost,
    output logic [dtlq_pkg::SUM_W-1:0]          delay_total_ns
);

    // configuration
    logic [dtlq_pkg::LIMIT_W-1:0] limit_reg;
    logic [dtlq_pkg::RATE_W-1:0]  rate_reg;

    // latched item
    logic                         drain_reg;
    logic [dtlq_pkg::TIME_W-1:0]  time_reg;
    logic [dtlq_pkg::SIZE_W-1:0]  bytes_reg;

    // queue state
    logic [dtlq_pkg::ENTRY_W-1:0] mem [dtlq_pkg::BUFFER_DEPTH];
    logic [dtlq_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [dtlq_pkg::PTR_W-1:0]   rptr_reg, rptr_next, wptr_reg;
    logic [dtlq_pkg::HELD_W-1:0]  held_reg;
    logic [dtlq_pkg::TIME_W-1:0]  dep_reg;
    logic                         admitted_reg;

    // counters
    logic [dtlq_pkg::CNT_W-1:0]   cin_reg, cout_reg, clost_reg;
    logic [dtlq_pkg::SUM_W-1:0]   bin_reg, bout_reg, blost_reg, wait_reg;

    // divider
    logic [dtlq_pkg::NUM_W-1:0]     quo_reg;
    logic [dtlq_pkg::RATE_W-1:0]    rem_reg;
    logic [dtlq_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic                           div_active_reg;
    logic [dtlq_pkg::TIME_W-1:0]    base_reg;

    logic [dtlq_pkg::RATE_W-1:0]    rate_eff;
    logic [dtlq_pkg::RATE_W:0]      rem_shift;
    logic                           rem_ge;
    logic [dtlq_pkg::SIZE_W-1:0]    div_size;
    logic [dtlq_pkg::NUM_W-1:0]     div_num;
    logic                           div_load;
    logic [dtlq_pkg::HELD_W-1:0]    limit_eff;
    logic                           room;
    logic [dtlq_pkg::TIME_W-1:0]    head_time;
    logic [dtlq_pkg::SIZE_W-1:0]    head_size;
    logic [dtlq_pkg::TIME_W:0]      dep_sum;
    logic [dtlq_pkg::TIME_W-1:0]    wait_delta;
    logic [dtlq_pkg::SUM_W:0]       wait_sum;

    // saturating add of a packet size to a byte sum
    function automatic logic [dtlq_pkg::SUM_W-1:0] sat48
    (
        input logic [dtlq_pkg::SUM_W-1:0]  acc,
        input logic [dtlq_pkg::SIZE_W-1:0] add
    );
        logic [dtlq_pkg::SUM_W:0] s;
        s = {1'b0, acc} + (dtlq_pkg::SUM_W + 1)'(add);
        return s[dtlq_pkg::SUM_W] ? '1 : s[dtlq_pkg::SUM_W-1:0];
    endfunction

    assign head_time = rd_data_reg[dtlq_pkg::ENTRY_W-1:dtlq_pkg::SIZE_W];
    assign head_size = rd_data_reg[dtlq_pkg::SIZE_W-1:0];

    // effective limits
    always_comb
    begin
        if (limit_reg > dtlq_pkg::LIMIT_W'(dtlq_pkg::BUFFER_DEPTH))
            limit_eff = dtlq_pkg::HELD_W'(dtlq_pkg::BUFFER_DEPTH);
        else
            limit_eff = dtlq_pkg::HELD_W'(limit_reg);
        rate_eff = (rate_reg == '0) ? dtlq_pkg::RATE_W'(1) : rate_reg;
    end

    assign room = (held_reg < limit_eff);

    // status to the sequencer
    always_comb
    begin
        status.retire_ok  = (held_reg != '0) && (drain_reg || (dep_reg <= time_reg));
        status.more_held  = (held_reg > dtlq_pkg::HELD_W'(1));
        status.div_needed = !drain_reg && room && (held_reg == '0);
        status.div_done   = div_active_reg && (div_cnt_reg == '0);
    end

    // divide operand selection
    always_comb
    begin
        div_load  = cmd.next_start || (cmd.admit && status.div_needed);
        div_size  = cmd.next_start ? head_size : bytes_reg;
        div_num   = dtlq_pkg::NUM_W'(div_size * dtlq_pkg::BITS_PER_KBYTE);
        rem_shift = {rem_reg, quo_reg[dtlq_pkg::NUM_W-1]};
        rem_ge    = (rem_shift >= {1'b0, rate_eff});
        dep_sum   = {1'b0, base_reg} + (dtlq_pkg::TIME_W + 1)'(quo_reg);
    end

    // wait charge for the new head
    always_comb
    begin
        wait_delta = (dep_reg > head_time) ? (dep_reg - head_time) : '0;
        wait_sum   = {1'b0, wait_reg} + {1'b0, wait_delta};
    end

    // read at the pointer the head will have next cycle
    assign rptr_next = cmd.retire ? rptr_reg + 1'b1 : rptr_reg;

    // queue memory
    always_ff @(posedge clk)
    begin
        if (cmd.admit && !drain_reg && room)
            mem[wptr_reg] <= {time_reg, bytes_reg};
        rd_data_reg <= mem[rptr_next];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= dtlq_pkg::LIMIT_RESET;
            rate_reg  <= dtlq_pkg::RATE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dtlq_pkg::REG_BUFFER_LIMIT: limit_reg <= cfg_data[dtlq_pkg::LIMIT_W-1:0];
                dtlq_pkg::REG_LINK_RATE:    rate_reg  <= cfg_data;
                default:                    rate_reg  <= rate_reg;
            endcase
        end
    end

    // latch the item
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            drain_reg <= mode;
            time_reg  <= arrival_time_ns;
            bytes_reg <= packet_bytes;
        end
    end

    // divider: one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_active_reg <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else if (div_load)
        begin
            div_active_reg <= 1'b1;
            div_cnt_reg    <= dtlq_pkg::DIV_CNT_W'(dtlq_pkg::NUM_W);
        end
        else if (cmd.load_dep)
        begin
            div_active_reg <= 1'b0;
        end
        else if (div_active_reg && (div_cnt_reg != '0))
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            quo_reg  <= div_num;
            rem_reg  <= '0;
            base_reg <= cmd.next_start ? dep_reg : time_reg;
        end
        else if (div_active_reg && (div_cnt_reg != '0))
        begin
            rem_reg <= rem_ge ? dtlq_pkg::RATE_W'(rem_shift - {1'b0, rate_eff})
                              : rem_shift[dtlq_pkg::RATE_W-1:0];
            quo_reg <= {quo_reg[dtlq_pkg::NUM_W-2:0], rem_ge};
        end
    end

    // queue control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg     <= '0;
            wptr_reg     <= '0;
            held_reg     <= '0;
            dep_reg      <= '0;
            admitted_reg <= 1'b0;
            cin_reg      <= '0;
            cout_reg     <= '0;
            clost_reg    <= '0;
            bin_reg      <= '0;
            bout_reg     <= '0;
            blost_reg    <= '0;
            wait_reg     <= '0;
        end
        else
        begin
            rptr_reg <= rptr_next;
            if (cmd.retire)
            begin
                held_reg <= held_reg - 1'b1;
                if (cout_reg != '1)
                    cout_reg <= cout_reg + 1'b1;
                bout_reg <= sat48(bout_reg, head_size);
            end
            if (cmd.next_start)
            begin
                wait_reg <= wait_sum[dtlq_pkg::SUM_W] ? '1 : wait_sum[dtlq_pkg::SUM_W-1:0];
            end
            if (cmd.load_dep)
            begin
                dep_reg <= dep_sum[dtlq_pkg::TIME_W] ? '1 : dep_sum[dtlq_pkg::TIME_W-1:0];
            end
            if (cmd.admit)
            begin
                admitted_reg <= !drain_reg && room;
                if (!drain_reg)
                begin
                    if (cin_reg != '1)
                        cin_reg <= cin_reg + 1'b1;
                    bin_reg <= sat48(bin_reg, bytes_reg);
                    if (room)
                    begin
                        wptr_reg <= wptr_reg + 1'b1;
                        held_reg <= held_reg + 1'b1;
                    end
                    else
                    begin
                        if (clost_reg != '1)
                            clost_reg <= clost_reg + 1'b1;
                        blost_reg <= sat48(blost_reg, bytes_reg);
                    end
                end
            end
        end
    end

    // result fields
    assign admitted       = admitted_reg;
    assign occupancy      = dtlq_pkg::LIMIT_W'(held_reg);
    assign packets_in     = cin_reg;
    assign bytes_in       = bin_reg;
    assign packets_out    = cout_reg;
    assign bytes_out      = bout_reg;
    assign packets_lost   = clost_reg;
    assign bytes_lost     = blost_reg;
    assign delay_total_ns = wait_reg;

endmodule

// File: test/drop_tail_link_queue_tb.sv
// Self-checking testbench for the tail-drop link queue: random and directed traffic.
module drop_tail_link_queue_tb;

    localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;

    typedef struct packed {
        logic                         admitted;
        logic [dtlq_pkg::LIMIT_W-1:0] occupancy;
        logic [dtlq_pkg::CNT_W-1:0]   packets_in;
        logic [dtlq_pkg::SUM_W-1:0]   bytes_in;
        logic [dtlq_pkg::CNT_W-1:0]   packets_out;
        logic [dtlq_pkg::SUM_W-1:0]   bytes_out;
        logic [dtlq_pkg::CNT_W-1:0]   packets_lost;
        logic [dtlq_pkg::SUM_W-1:0]   bytes_lost;
        logic [dtlq_pkg::SUM_W-1:0]   delay_total_ns;
    } link_stats_t;

    // Predicts the counters of the queue and checks each result beat
    class tail_drop_tracker;
        longint unsigned arr_t[dtlq_pkg::BUFFER_DEPTH];
        longint unsigned size_q[dtlq_pkg::BUFFER_DEPTH];
        longint unsigned head_dep;
        int              rd_idx, wr_idx, held;
        longint unsigned n_in, b_in, n_out, b_out, n_lost, b_lost, wait_sum;
        int unsigned     limit, rate;
        link_stats_t     pending_stats[$];
        int              errors;

        function new();
            head_dep = 0; rd_idx = 0; wr_idx = 0; held = 0;
            n_in = 0; b_in = 0; n_out = 0; b_out = 0;
            n_lost = 0; b_lost = 0; wait_sum = 0;
            limit = 64; rate = 100; errors = 0;
        endfunction

        function void set_reg(logic idx, logic [dtlq_pkg::RATE_W-1:0] data);
            if (idx == dtlq_pkg::REG_BUFFER_LIMIT)
                limit = 32'(data[dtlq_pkg::LIMIT_W-1:0]);
            else
                rate = 32'(data);
        endfunction

        function longint unsigned svc_ns(longint unsigned nbytes);
            longint unsigned r;
            r = (rate == 0) ? 1 : rate;
            return (nbytes * 8000) / r;
        endfunction

        function longint unsigned sat(longint unsigned a, longint unsigned b,
                                      longint unsigned max);
            longint unsigned s;
            s = a + b;
            return (s > max) ? max : s;
        endfunction

        // Retire the head packet and start service of the next one
        function void retire_head();
            longint unsigned dep;
            dep = head_dep;
            n_out = sat(n_out, 1, 64'hFFFF_FFFF);
            b_out = sat(b_out, size_q[rd_idx], TIME_MAX);
            rd_idx = (rd_idx + 1) % dtlq_pkg::BUFFER_DEPTH;
            held--;
            if (held > 0)
            begin
                if (dep > arr_t[rd_idx])
                    wait_sum = sat(wait_sum, dep - arr_t[rd_idx], TIME_MAX);
                head_dep = sat(dep, svc_ns(size_q[rd_idx]), TIME_MAX);
            end
        endfunction

        function void note_item(logic drain, longint unsigned t, longint unsigned nbytes);
            link_stats_t exp_s;
            int unsigned lim;
            bit adm;
            adm = 0;
            while (held > 0 && (drain || head_dep <= t))
                retire_head();
            if (!drain)
            begin
                n_in = sat(n_in, 1, 64'hFFFF_FFFF);
                b_in = sat(b_in, nbytes, TIME_MAX);
                lim = (limit > dtlq_pkg::BUFFER_DEPTH) ? dtlq_pkg::BUFFER_DEPTH : limit;
                if (held < lim)
                begin
                    arr_t[wr_idx] = t;
                    size_q[wr_idx] = nbytes;
                    wr_idx = (wr_idx + 1) % dtlq_pkg::BUFFER_DEPTH;
                    held++;
                    if (held == 1)
                        head_dep = sat(t, svc_ns(nbytes), TIME_MAX);
                    adm = 1;
                end
                else
                begin
                    n_lost = sat(n_lost, 1, 64'hFFFF_FFFF);
                    b_lost = sat(b_lost, nbytes, TIME_MAX);
                end
            end
            exp_s.admitted       = adm;
            exp_s.occupancy      = dtlq_pkg::LIMIT_W'(held);
            exp_s.packets_in     = n_in[dtlq_pkg::CNT_W-1:0];
            exp_s.bytes_in       = b_in[dtlq_pkg::SUM_W-1:0];
            exp_s.packets_out    = n_out[dtlq_pkg::CNT_W-1:0];
            exp_s.bytes_out      = b_out[dtlq_pkg::SUM_W-1:0];
            exp_s.packets_lost   = n_lost[dtlq_pkg::CNT_W-1:0];
            exp_s.bytes_lost     = b_lost[dtlq_pkg::SUM_W-1:0];
            exp_s.delay_total_ns = wait_sum[dtlq_pkg::SUM_W-1:0];
            pending_stats = {pending_stats, exp_s};
        endfunction

        function void cmp(string name, longint unsigned e, longint unsigned a);
            if (e != a)
            begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_beat(link_stats_t got);
            link_stats_t e;
            if (pending_stats.size() == 0)
            begin
                $error("result beat with no item outstanding");
                errors++;
                return;
            end
            e = pending_stats.pop_front();
            cmp("admitted", e.admitted, got.admitted);
            cmp("occupancy", e.occupancy, got.occupancy);
            cmp("packets_in", e.packets_in, got.packets_in);
            cmp("bytes_in", e.bytes_in, got.bytes_in);
            cmp("packets_out", e.packets_out, got.packets_out);
            cmp("bytes_out", e.bytes_out, got.bytes_out);
            cmp("packets_lost", e.packets_lost, got.packets_lost);
            cmp("bytes_lost", e.bytes_lost, got.bytes_lost);
            cmp("delay_total_ns", e.delay_total_ns, got.delay_total_ns);
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          mode;
    logic [dtlq_pkg::TIME_W-1:0]   arrival_time_ns;
    logic [dtlq_pkg::SIZE_W-1:0]   packet_bytes;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic [dtlq_pkg::RATE_W-1:0]   cfg_data;
    logic                          done;
    link_stats_t                   got;

    tail_drop_tracker   tracker;
    longint unsigned    cycle_count;
    longint unsigned    t_cur;

    drop_tail_link_queue dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .arrival_time_ns (arrival_time_ns),
        .packet_bytes    (packet_bytes),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .admitted        (got.admitted),
        .occupancy       (got.occupancy),
        .packets_in      (got.packets_in),
        .bytes_in        (got.bytes_in),
        .packets_out     (got.packets_out),
        .bytes_out       (got.bytes_out),
        .packets_lost    (got.packets_lost),
        .bytes_lost      (got.bytes_lost),
        .delay_total_ns  (got.delay_total_ns)
    );

    // Generate the clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Check each result beat
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_beat(got);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Pick an idle gap: mostly short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 60);
    endfunction

    // Write one register; called at a falling edge
    task automatic write_reg(logic idx, logic [dtlq_pkg::RATE_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        tracker.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send one item; called at a falling edge, returns at a falling edge
    task automatic send_item(logic drain, longint unsigned t, longint unsigned nbytes,
                             int gap);
        start           = 1'b1;
        mode            = drain;
        arrival_time_ns = t[dtlq_pkg::TIME_W-1:0];
        packet_bytes    = nbytes[dtlq_pkg::SIZE_W-1:0];
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        tracker.note_item(drain, t, nbytes);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold off until every result has come back
    task automatic settle();
        start = 1'b0;
        while (tracker.pending_stats.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Random phase of traffic, closed by a drain
    task automatic run_phase(int n_items, longint unsigned base);
        int r;
        longint unsigned span, t;
        t_cur = base;
        span = tracker.svc_ns(1500) * 2 + 1;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 7)
            begin
                send_item(1'b1, {$urandom, $urandom}, 64'($urandom), pick_gap());
            end
            else if (r < 11)
            begin
                // out-of-order arrival
                t = (t_cur > span) ? t_cur - $urandom_range(0, 32'(span)) : 0;
                send_item(1'b0, t, $urandom_range(0, 65535), pick_gap());
            end
            else
            begin
                if (r < 20)
                    t = 0;
                else
                    t = {$urandom, $urandom} % span;
                t_cur = (t_cur + t > TIME_MAX) ? TIME_MAX : t_cur + t;
                send_item(1'b0, t_cur,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(40, 1500),
                          pick_gap());
            end
        end
        send_item(1'b1, 0, 0, 0);
        settle();
    endtask

    initial
    begin
        tracker         = new();
        cycle_count     = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        mode            = 1'b0;
        arrival_time_ns = '0;
        packet_bytes    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = dtlq_pkg::REG_BUFFER_LIMIT;
        cfg_data        = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed: reset settings, extremes of size, equal times, drains
        send_item(1'b1, 0, 0, 0);
        send_item(1'b0, 0, 0, 0);
        send_item(1'b0, 0, 65535, 0);
        send_item(1'b0, 10, 1000, 1);
        send_item(1'b0, 5, 100, 0);
        send_item(1'b0, 5242800, 1, 0);
        send_item(1'b0, 5242800, 1, 2);
        send_item(1'b0, 5322880, 1500, 0);
        send_item(1'b1, TIME_MAX, 65535, 0);
        send_item(1'b1, 0, 0, 0);
        settle();

        // Directed: zero limit drops everything
        write_reg(dtlq_pkg::REG_BUFFER_LIMIT, dtlq_pkg::RATE_W'(0));
        send_item(1'b0, 100, 64, 0);
        send_item(1'b0, 200, 65535, 0);
        settle();

        // Directed: zero rate and departure saturation near the end of time
        write_reg(dtlq_pkg::REG_BUFFER_LIMIT, dtlq_pkg::RATE_W'(127));
        write_reg(dtlq_pkg::REG_LINK_RATE, dtlq_pkg::RATE_W'(0));
        send_item(1'b0, TIME_MAX - 1000, 65535, 0);
        send_item(1'b0, TIME_MAX - 999, 65535, 0);
        send_item(1'b0, TIME_MAX - 10, 65535, 0);
        send_item(1'b0, TIME_MAX, 1, 0);
        send_item(1'b0, TIME_MAX, 2, 0);
        send_item(1'b1, 0, 0, 0);
        settle();

        // Random phases across settings, extremes included
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 6)
                0: write_reg(dtlq_pkg::REG_BUFFER_LIMIT, dtlq_pkg::RATE_W'(64));
                1: write_reg(dtlq_pkg::REG_BUFFER_LIMIT, dtlq_pkg::RATE_W'(1));
                2: write_reg(dtlq_pkg::REG_BUFFER_LIMIT,
                             dtlq_pkg::RATE_W'($urandom_range(2, 63)));
                3: write_reg(dtlq_pkg::REG_BUFFER_LIMIT, dtlq_pkg::RATE_W'(127));
                4: write_reg(dtlq_pkg::REG_BUFFER_LIMIT,
                             dtlq_pkg::RATE_W'($urandom_range(65, 127)));
                default: write_reg(dtlq_pkg::REG_BUFFER_LIMIT,
                                   dtlq_pkg::RATE_W'($urandom_range(0, 127)));
            endcase
            case (ph % 4)
                0: write_reg(dtlq_pkg::REG_LINK_RATE, dtlq_pkg::RATE_W'(100000));
                1: write_reg(dtlq_pkg::REG_LINK_RATE,
                             dtlq_pkg::RATE_W'($urandom_range(1, 1000)));
                2: write_reg(dtlq_pkg::REG_LINK_RATE, 17'h1FFFF);
                default: write_reg(dtlq_pkg::REG_LINK_RATE,
                                   dtlq_pkg::RATE_W'($urandom_range(1, 100000)));
            endcase
            run_phase(93, (ph % 5 == 4) ? TIME_MAX - $urandom_range(0, 1000000000)
                                         : {16'h0, $urandom} >> $urandom_range(0, 31));
        end
        write_reg(dtlq_pkg::REG_LINK_RATE, dtlq_pkg::RATE_W'(1));
        write_reg(dtlq_pkg::REG_BUFFER_LIMIT, dtlq_pkg::RATE_W'(64));
        run_phase(20, 0);

        if (tracker.errors == 0 && tracker.pending_stats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
sv/dtlq_pkg.sv
sv/dtlq_ctrl.sv
sv/dtlq_dpath.sv
sv/drop_tail_link_queue.sv
test/drop_tail_link_queue_tb.sv
